// ===== hdl/i2da_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2da_pkg
// Shared types and constants for the integer to decimal ASCII converter.
// ---------------------------------------------------------------------------
package i2da_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int CHAR_W          = 6;
    localparam int DIGIT_W         = 4;
    localparam int M_TDATA_W       = 8;

    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0]  CHAR_NINE  = 6'd57;

    // Double-dabble correction: a digit of five or more gets three added before the shift.
    localparam logic [DIGIT_W-1:0] DIGIT_ADJ_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] DIGIT_ADJ_ADD = 4'd3;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_CONV,
        CELL_SHIFT
    } cell_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_EMIT
    } state_t;

endpackage

// ===== hdl/i2da_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2da_cell
// One decimal digit of the conversion chain. Clears, holds, shifts in one binary
// bit per cycle with the add-three correction, or passes its digit one place up.
// ---------------------------------------------------------------------------
module i2da_cell (
    input  logic                               aclk,
    input  i2da_pkg::cell_mode_t               mode,
    input  logic                               conv_in,   // bit from the lower cell
    input  logic [i2da_pkg::DIGIT_W-1:0]       shift_in,  // digit from the lower cell
    output logic [i2da_pkg::DIGIT_W-1:0]       digit,
    output logic                               carry      // bit to the upper cell
);
    import i2da_pkg::*;

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W-1:0] adj;

    always_comb begin
        adj = (digit_reg >= DIGIT_ADJ_MIN) ? (digit_reg + DIGIT_ADJ_ADD) : digit_reg;
    end

    always_comb begin
        case (mode)
            CELL_CLEAR: digit_next = '0;
            CELL_CONV:  digit_next = {adj[DIGIT_W-2:0], conv_in};
            CELL_SHIFT: digit_next = shift_in;
            default:    digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

    assign digit = digit_reg;
    assign carry = adj[DIGIT_W-1];

endmodule

// ===== hdl/int_to_decimal_ascii_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// int_to_decimal_ascii_unit
// Signed integer to decimal ASCII text, one character per output beat.
// ---------------------------------------------------------------------------
// Each input beat carries one signed VALUE_WIDTH-bit integer; the output is
// its decimal text, most significant character first, with a leading '-' for
// negative values, leading zeros dropped, and tlast on the final character.
// The magnitude is shifted MSB first through a row of BCD digit cells, one
// bit per cycle, then the cells shift their digits up toward the output one
// per cycle while the output does not stall. NDIG is the number of digit
// cells (10 at 32 bits); the sign takes its own step before the digits, and
// a skipped leading zero takes a shift step like an emitted digit. A new
// input beat is taken only once the previous text is all in the output register.
// ---------------------------------------------------------------------------
module int_to_decimal_ascii_unit #(
    parameter int VALUE_WIDTH = i2da_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_tdata,   // [VALUE_WIDTH-1:0] value
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [i2da_pkg::M_TDATA_W-1:0]       m_tdata,   // [5:0] character
    output logic                                 m_tlast
);
    import i2da_pkg::*;

    // Decimal digits for a magnitude of up to 2^(VALUE_WIDTH-1).
    localparam int NDIG      = (((VALUE_WIDTH - 1) * 1233) >> 12) + 1;
    localparam int BIT_CNT_W = $clog2(VALUE_WIDTH + 1);
    localparam int REM_W     = $clog2(NDIG + 1);

    state_t                 state_reg, state_next;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [BIT_CNT_W-1:0]   bits_reg, bits_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic                   started_reg, started_next;

    logic                   m_tvalid_reg;
    logic [CHAR_W-1:0]      char_reg;
    logic                   last_reg;

    cell_mode_t             cell_mode;
    logic                   out_load;
    logic [CHAR_W-1:0]      out_char;
    logic                   out_last;
    logic                   slot_free;

    logic [VALUE_WIDTH-1:0] value_in;
    logic [DIGIT_W-1:0]     digit [NDIG];
    logic                   carry [NDIG];
    logic [DIGIT_W-1:0]     top_digit;

    assign value_in  = s_tdata[VALUE_WIDTH-1:0];
    assign top_digit = digit[NDIG-1];
    assign slot_free = !m_tvalid_reg || m_tready;

    // Cell 0 holds the least significant digit.
    genvar g;
    generate
        for (g = 0; g < NDIG; g++) begin : g_cell
            if (g == 0) begin : g_first
                i2da_cell u_cell (
                    .aclk     (aclk),
                    .mode     (cell_mode),
                    .conv_in  (mag_reg[VALUE_WIDTH-1]),
                    .shift_in ({DIGIT_W{1'b0}}),
                    .digit    (digit[g]),
                    .carry    (carry[g])
                );
            end else begin : g_rest
                i2da_cell u_cell (
                    .aclk     (aclk),
                    .mode     (cell_mode),
                    .conv_in  (carry[g-1]),
                    .shift_in (digit[g-1]),
                    .digit    (digit[g]),
                    .carry    (carry[g])
                );
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            neg_reg      <= 1'b0;
            bits_reg     <= '0;
            rem_reg      <= '0;
            started_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            neg_reg     <= neg_next;
            bits_reg    <= bits_next;
            rem_reg     <= rem_next;
            started_reg <= started_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg <= mag_next;
        if (out_load) begin
            char_reg <= out_char;
            last_reg <= out_last;
        end
    end

    always_comb begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        bits_next    = bits_reg;
        rem_next     = rem_reg;
        started_next = started_reg;
        cell_mode    = CELL_HOLD;
        out_load     = 1'b0;
        out_char     = CHAR_ZERO;
        out_last     = 1'b0;
        s_tready     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                cell_mode = CELL_CLEAR;
                if (s_tvalid) begin
                    neg_next   = value_in[VALUE_WIDTH-1];
                    mag_next   = value_in[VALUE_WIDTH-1] ? ('0 - value_in) : value_in;
                    bits_next  = BIT_CNT_W'(VALUE_WIDTH);
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cell_mode = CELL_CONV;
                mag_next  = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                bits_next = bits_reg - 1'b1;
                if (bits_reg == BIT_CNT_W'(1)) begin
                    rem_next     = REM_W'(NDIG);
                    started_next = 1'b0;
                    state_next   = ST_SIGN;
                end
            end
            ST_SIGN: begin
                if (!neg_reg) begin
                    state_next = ST_EMIT;
                end else if (slot_free) begin
                    out_load   = 1'b1;
                    out_char   = CHAR_MINUS;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!started_reg && top_digit == '0 && rem_reg != REM_W'(1)) begin
                    // drop a leading zero
                    cell_mode = CELL_SHIFT;
                    rem_next  = rem_reg - 1'b1;
                end else if (slot_free) begin
                    out_load     = 1'b1;
                    out_char     = CHAR_ZERO + CHAR_W'(top_digit);
                    out_last     = (rem_reg == REM_W'(1));
                    cell_mode    = CELL_SHIFT;
                    rem_next     = rem_reg - 1'b1;
                    started_next = 1'b1;
                    if (rem_reg == REM_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-CHAR_W){1'b0}}, char_reg};
    assign m_tlast  = last_reg;

    // The magnitude always fits the digit row: nothing leaves the top cell.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONV) |-> !carry[NDIG-1])
        else $error("digit row overflow");

    a_rem_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (rem_reg != '0))
        else $error("emit with no digits left");

    a_char_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (char_reg == CHAR_MINUS ||
                          (char_reg >= CHAR_ZERO && char_reg <= CHAR_NINE)))
        else $error("output character out of range");

    a_minus_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && char_reg == CHAR_MINUS) |-> !last_reg)
        else $error("minus sign marked last");

endmodule
